// ===== hdl/critically_damped_smoother_unit_defines.svh =====
// Assertion macros for the critically damped smoother.
// Each macro needs clk and rst_n in the scope where it is used.
`ifndef CRITICALLY_DAMPED_SMOOTHER_UNIT_DEFINES_SVH
`define CRITICALLY_DAMPED_SMOOTHER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define CDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cds assertion failed");
// Next-cycle implication
`define CDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cds assertion failed");
`else
`define CDS_ASSERT_NOW(label, ante, cons)
`define CDS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hdl/cds_pkg.sv =====
`default_nettype none

package cds_pkg;

    typedef logic signed [31:0] q_t;

    localparam int TSTEP_W = 20;
    localparam int REG_W   = 31;
    localparam int CFG_IDX_W = 1;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_TIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 1'b1;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DIV_OMEGA = 6'b000010,
        S_MUL_ISSUE = 6'b000100,
        S_MUL_DONE  = 6'b001000,
        S_DIV_DECAY = 6'b010000,
        S_FINISH    = 6'b100000
    } state_t;

    // Multiply steps, in issue order
    typedef enum logic [3:0] {
        OP_X      = 4'd0,
        OP_X2     = 4'd1,
        OP_X3     = 4'd2,
        OP_DEN2   = 4'd3,
        OP_DEN3   = 4'd4,
        OP_MAXCHG = 4'd5,
        OP_VDRIVE = 4'd6,
        OP_TMP    = 4'd7,
        OP_VBRAKE = 4'd8,
        OP_VEL    = 4'd9,
        OP_POS    = 4'd10
    } op_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Saturate a 33-bit exact sum to 32 bits
    function automatic q_t sat33(input logic signed [32:0] v);
        q_t r;
        if (v[32] != v[31])
            r = v[32] ? Q_MIN : Q_MAX;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic q_t add_sat(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) + $signed({b[31], b});
        return sat33(s);
    endfunction

    function automatic q_t sub_sat(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) - $signed({b[31], b});
        return sat33(s);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cds_if.sv =====
`default_nettype none

// Input channel: one word per smoothing step
interface cds_in_if import cds_pkg::*;;
    logic               valid;
    logic               ready;
    q_t                 current_pos;
    q_t                 target_pos;
    logic [TSTEP_W-1:0] time_step;

    modport source (output valid, output current_pos, output target_pos,
                    output time_step, input ready);
    modport sink   (input valid, input current_pos, input target_pos,
                    input time_step, output ready);
endinterface

// Result channel: one word per step
interface cds_out_if import cds_pkg::*;;
    logic valid;
    logic ready;
    q_t   new_pos;
    q_t   new_velocity;
    logic pinned;

    modport source (output valid, output new_pos, output new_velocity,
                    output pinned, input ready);
    modport sink   (input valid, input new_pos, input new_velocity,
                    input pinned, output ready);
endinterface

// Configuration write channel
interface cds_cfg_if import cds_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/critically_damped_smoother_unit.sv =====
// Channel  Dir   Word
// -------  ----  -------------------------------------------------
// item     in    current_pos, target_pos (Q signed 32), time_step (20)
// result   out   new_pos, new_velocity (Q signed 32), pinned
// cfg      in    index (0 smooth_time, 1 max_speed), data (31)
//
// One item at a time. Each item runs two divisions of one quotient bit per
// cycle (omega, decay) and eleven passes through the shared multiplier;
// a zero time step skips both. item.ready is high only in idle; a finished
// word waits in the result register while the next item is taken, and the
// sequencer stalls before its final write if that register is still full.
// Reset clears velocity to zero and loads smooth_time = 1.0, max_speed = max.
`default_nettype none
`include "critically_damped_smoother_unit_defines.svh"

module critically_damped_smoother_unit import cds_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    cds_in_if.sink     item,
    cds_out_if.source  result,
    cds_cfg_if.sink    cfg
);

    localparam int NUM_W = (2 * FRAC_BITS + 2 > 32) ? 2 * FRAC_BITS + 2 : 32;
    localparam longint ONE_L     = 64'sd1 << FRAC_BITS;
    localparam longint FLOOR_RAW = (ONE_L + 5000) / 10000;
    localparam longint FLOOR_L   = (FLOOR_RAW < 1) ? 1 : FLOOR_RAW;
    localparam longint C48_L     = (48 * ONE_L + 50) / 100;
    localparam longint C235_L    = (235 * ONE_L + 500) / 1000;

    localparam logic [REG_W-1:0] FLOOR_ST = REG_W'(FLOOR_L);
    localparam q_t ONE_Q  = 32'(ONE_L);
    localparam q_t C48_Q  = 32'(C48_L);
    localparam q_t C235_Q = 32'(C235_L);
    localparam logic [NUM_W-1:0] OMEGA_NUM = NUM_W'(1) << (2 * FRAC_BITS + 1);
    localparam logic [NUM_W-1:0] DECAY_NUM = NUM_W'(1) << (2 * FRAC_BITS);

    state_t state_reg, state_next;
    op_t    op_reg;

    logic [REG_W-1:0]   smooth_time_reg;
    logic [REG_W-1:0]   max_speed_reg;
    q_t                 vel_reg;

    q_t                 cur_reg, tgt_reg;
    logic [TSTEP_W-1:0] dt_reg;
    logic [REG_W-1:0]   st_reg;
    logic               hold_reg;
    q_t                 omega_reg, x_reg, x2_reg, x3_reg, den_reg, decay_reg;
    q_t                 chg_reg, near_reg, acc_reg, tmp_reg, vnew_reg, pos_reg;

    logic               out_valid_reg;
    q_t                 new_pos_reg, new_vel_reg;
    logic               pinned_reg;

    logic               in_acc;
    logic               fin_go;
    logic [REG_W-1:0]   st_sel;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [REG_W-1:0]   div_den;
    logic [NUM_W-1:0]   div_quot;
    div_stat_t          div_stat;
    q_t                 den_fin;
    q_t                 mul_a, mul_b, mres, neg_max;
    logic signed [32:0] tgt_minus_cur;
    logic               pin;

    assign in_acc     = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign fin_go     = (state_reg == S_FINISH) && (!out_valid_reg || result.ready);
    assign cfg.ready  = 1'b1;

    // Floor the smooth time
    assign st_sel = (smooth_time_reg < FLOOR_ST) ? FLOOR_ST : smooth_time_reg;

    // Complete denominator, including the cubic term retiring this cycle
    assign den_fin = add_sat(den_reg, mres);

    // Divider operands: omega at accept, decay as the last denominator term retires
    assign div_start = (in_acc && (item.time_step != '0))
                    || (state_reg == S_MUL_DONE && op_reg == OP_DEN3);
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            div_num = OMEGA_NUM + {{(NUM_W-REG_W+1){1'b0}}, st_sel[REG_W-1:1]};
            div_den = st_sel;
        end
        else
        begin
            div_num = DECAY_NUM + {{(NUM_W-REG_W+1){1'b0}}, den_fin[REG_W-1:1]};
            div_den = den_fin[REG_W-1:0];
        end
    end

    cds_div #(
        .NUM_W (NUM_W),
        .DEN_W (REG_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    // Select multiplier operands for the current step
    always_comb
    begin
        case (op_reg)
            OP_X:      begin mul_a = omega_reg; mul_b = {{(32-TSTEP_W){1'b0}}, dt_reg}; end
            OP_X2:     begin mul_a = x_reg;     mul_b = x_reg;     end
            OP_X3:     begin mul_a = x2_reg;    mul_b = x_reg;     end
            OP_DEN2:   begin mul_a = C48_Q;     mul_b = x2_reg;    end
            OP_DEN3:   begin mul_a = C235_Q;    mul_b = x3_reg;    end
            OP_MAXCHG: begin mul_a = {1'b0, max_speed_reg}; mul_b = {1'b0, st_reg}; end
            OP_VDRIVE: begin mul_a = omega_reg; mul_b = chg_reg;   end
            OP_TMP:    begin mul_a = acc_reg;   mul_b = {{(32-TSTEP_W){1'b0}}, dt_reg}; end
            OP_VBRAKE: begin mul_a = omega_reg; mul_b = tmp_reg;   end
            OP_VEL:    begin mul_a = acc_reg;   mul_b = decay_reg; end
            OP_POS:    begin mul_a = acc_reg;   mul_b = decay_reg; end
            default:   begin mul_a = '0;        mul_b = '0;        end
        endcase
    end

    cds_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mres)
    );

    assign neg_max = -mres;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = (item.time_step == '0) ? S_FINISH : S_DIV_OMEGA;
            end
            S_DIV_OMEGA:
            begin
                if (div_stat.done)
                    state_next = S_MUL_ISSUE;
            end
            S_MUL_ISSUE:
            begin
                state_next = S_MUL_DONE;
            end
            S_MUL_DONE:
            begin
                if (op_reg == OP_DEN3)
                    state_next = S_DIV_DECAY;
                else if (op_reg == OP_POS)
                    state_next = S_FINISH;
                else
                    state_next = S_MUL_ISSUE;
            end
            S_DIV_DECAY:
            begin
                if (div_stat.done)
                    state_next = S_MUL_ISSUE;
            end
            S_FINISH:
            begin
                if (fin_go)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and stored velocity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_X;
            smooth_time_reg <= REG_W'(ONE_L);
            max_speed_reg   <= '1;
            vel_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
                op_reg <= OP_X;
            else if (state_reg == S_MUL_DONE && op_reg != OP_POS)
                op_reg <= op_t'(op_reg + 1'b1);

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_SMOOTH_TIME: smooth_time_reg <= cfg.data;
                    CFG_MAX_SPEED:   max_speed_reg   <= cfg.data;
                    default:         ;
                endcase
            end

            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
                vel_reg       <= hold_reg ? vel_reg : (pin ? '0 : vnew_reg);
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Overshoot guard
    assign tgt_minus_cur = $signed({tgt_reg[31], tgt_reg}) - $signed({cur_reg[31], cur_reg});
    assign pin = ((tgt_minus_cur > 0) == (pos_reg > tgt_reg));

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cur_reg  <= item.current_pos;
            tgt_reg  <= item.target_pos;
            dt_reg   <= item.time_step;
            st_reg   <= st_sel;
            hold_reg <= (item.time_step == '0);
            chg_reg  <= sub_sat(item.current_pos, item.target_pos);
        end

        // Saturate the quotient into omega; decay always fits
        if (state_reg == S_DIV_OMEGA && div_stat.done)
            omega_reg <= (|div_quot[NUM_W-1:REG_W]) ? Q_MAX : {1'b0, div_quot[REG_W-1:0]};
        if (state_reg == S_DIV_DECAY && div_stat.done)
            decay_reg <= div_quot[31:0];

        // Retire each multiply step
        if (state_reg == S_MUL_DONE)
        begin
            case (op_reg)
                OP_X:      x_reg <= mres;
                OP_X2:
                begin
                    x2_reg  <= mres;
                    den_reg <= add_sat(ONE_Q, x_reg);
                end
                OP_X3:     x3_reg  <= mres;
                OP_DEN2:   den_reg <= add_sat(den_reg, mres);
                OP_DEN3:   den_reg <= add_sat(den_reg, mres);
                OP_MAXCHG:
                begin
                    if (chg_reg > mres)
                        chg_reg <= mres;
                    else if (chg_reg < neg_max)
                        chg_reg <= neg_max;
                end
                OP_VDRIVE:
                begin
                    acc_reg  <= add_sat(vel_reg, mres);
                    near_reg <= sub_sat(cur_reg, chg_reg);
                end
                OP_TMP:    tmp_reg <= mres;
                OP_VBRAKE: acc_reg <= sub_sat(vel_reg, mres);
                OP_VEL:
                begin
                    vnew_reg <= mres;
                    acc_reg  <= add_sat(chg_reg, tmp_reg);
                end
                OP_POS:    pos_reg <= add_sat(near_reg, mres);
                default:   ;
            endcase
        end

        // Load the result word
        if (fin_go)
        begin
            if (hold_reg)
            begin
                new_pos_reg <= cur_reg;
                new_vel_reg <= vel_reg;
                pinned_reg  <= 1'b0;
            end
            else if (pin)
            begin
                new_pos_reg <= tgt_reg;
                new_vel_reg <= '0;
                pinned_reg  <= 1'b1;
            end
            else
            begin
                new_pos_reg <= pos_reg;
                new_vel_reg <= vnew_reg;
                pinned_reg  <= 1'b0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.new_pos      = new_pos_reg;
    assign result.new_velocity = new_vel_reg;
    assign result.pinned       = pinned_reg;

    // Checks
    `CDS_ASSERT_NOW(a_div_idle_on_start, div_start, !div_stat.busy)
    `CDS_ASSERT_NOW(a_div_idle_in_mul,
        (state_reg == S_MUL_ISSUE) || (state_reg == S_MUL_DONE), !div_stat.busy)
    `CDS_ASSERT_NOW(a_pinned_stops, result.valid && result.pinned,
        result.new_velocity == '0)
    `CDS_ASSERT_NEXT(a_vel_matches_out, fin_go, vel_reg == result.new_velocity)

endmodule

`default_nettype wire

// ===== hdl/cds_mul.sv =====
`default_nettype none

// Shared fixed-point multiplier: registered 64-bit product, then
// floor shift by FRAC_BITS and saturation to 32 bits.
module cds_mul import cds_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  q_t   a,
    input  q_t   b,
    output q_t   prod
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] shifted;
    logic               ovf;

    // Register the full product
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    // Arithmetic shift rounds toward minus infinity
    assign shifted = prod_reg >>> FRAC_BITS;
    assign ovf     = (|shifted[63:31]) && !(&shifted[63:31]);
    assign prod    = ovf ? (shifted[63] ? Q_MIN : Q_MAX) : shifted[31:0];

endmodule

`default_nettype wire

// ===== hdl/cds_div.sv =====
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module cds_div import cds_pkg::*; #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output div_stat_t        stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] nq_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic             stepping;

    // Trial subtract of the shifted remainder
    assign rem_sh   = {rem_reg, nq_reg[NUM_W-1]};
    assign diff     = rem_sh - {1'b0, den_reg};
    assign ge       = !diff[DEN_W];
    assign stepping = busy_reg && (cnt_reg != '0);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (stepping)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // Datapath: dividend shifts out at the top, quotient fills from the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (stepping)
        begin
            nq_reg  <= {nq_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign quot      = nq_reg;
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == '0);

endmodule

`default_nettype wire
